FILE: rtl/core/spvs_pkg.sv
`timescale 1ns / 1ps
package spvs_pkg;

  // Input word: panorama write data or a view pixel to project.
  typedef struct packed {
    logic        command;
    logic [9:0]  pano_row;
    logic [10:0] pano_col;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [7:0]  mask_in;
    logic [8:0]  view_row;
    logic [9:0]  view_col;
  } in_word_t;

  // Result word: one per projected pixel.
  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic [7:0]  mask_out;
    logic [8:0]  echo_row;
    logic [9:0]  echo_col;
  } out_word_t;

  // Command codes.
  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_PROJECT = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_LENGTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PANO_HEIGHT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PANO_WIDTH   = 3'd5;

  // Datapath widths.
  localparam int COORD_W = 42;   // CORDIC x/y, rotated ray times 256 plus growth
  localparam int ANGLE_W = 24;   // angles, a half turn is 2^20
  localparam int WGT_W   = 17;   // product of two 9-bit bilinear weights
  localparam int ANGLE_HALF_TURN = 1048576;
  localparam int CORDIC_STEPS    = 20;
  localparam int CORDIC_GAIN_Q24 = 27628053;

  // Arctangent of 2^-i in angle units, rounded to nearest.
  function automatic logic signed [ANGLE_W-1:0] atan_step(input int unsigned i);
    logic signed [ANGLE_W-1:0] a;
    unique case (i)
      0:  a = 24'sd262144;
      1:  a = 24'sd154753;
      2:  a = 24'sd81767;
      3:  a = 24'sd41506;
      4:  a = 24'sd20834;
      5:  a = 24'sd10427;
      6:  a = 24'sd5215;
      7:  a = 24'sd2608;
      8:  a = 24'sd1304;
      9:  a = 24'sd652;
      10: a = 24'sd326;
      11: a = 24'sd163;
      12: a = 24'sd81;
      13: a = 24'sd41;
      14: a = 24'sd20;
      15: a = 24'sd10;
      16: a = 24'sd5;
      17: a = 24'sd3;
      18: a = 24'sd1;
      19: a = 24'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/core/spvs_project.sv
`timescale 1ns / 1ps
module spvs_project #(
  parameter int VIEW_HEIGHT = 480,
  parameter int VIEW_WIDTH  = 640
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  spvs_pkg::in_word_t                   in_word,
  input  logic [47:0]                          rot_row0,
  input  logic [47:0]                          rot_row1,
  input  logic [47:0]                          rot_row2,
  input  logic [11:0]                          focal_length,
  output logic                                 out_valid,
  output spvs_pkg::in_word_t                   out_word,
  output logic signed [spvs_pkg::COORD_W-1:0]  x0,
  output logic signed [spvs_pkg::COORD_W-1:0]  y0,
  output logic signed [spvs_pkg::ANGLE_W-1:0]  z0,
  output logic signed [spvs_pkg::COORD_W-1:0]  zg
);
  import spvs_pkg::*;

  logic signed [13:0] ray [3];
  logic [47:0]        rows [3];
  logic signed [29:0] prod [3][3];
  logic signed [31:0] sum [3];
  logic               v1, v2;
  in_word_t           w1, w2;
  logic signed [57:0] zprod;
  logic signed [COORD_W-1:0] tx, ty;

  // Viewing ray relative to the view center.
  assign ray[0] = $signed({2'b00, focal_length});
  assign ray[1] = $signed({4'b0000, in_word.view_col}) - 14'(VIEW_WIDTH / 2);
  assign ray[2] = $signed({5'b00000, in_word.view_row}) - 14'(VIEW_HEIGHT / 2);
  assign rows[0] = rot_row0;
  assign rows[1] = rot_row1;
  assign rows[2] = rot_row2;

  // Stage 1: the nine coefficient products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod[r][k] <= $signed(rows[r][16*k +: 16]) * ray[k];
        end
      end
      w1 <= in_word;
    end
  end

  // Stage 2: row sums give the rotated ray.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        sum[r] <= 32'(prod[r][0]) + 32'(prod[r][1]) + 32'(prod[r][2]);
      end
      w2 <= w1;
    end
  end

  // Stage 3: fold the ray into the right half plane and scale z by the CORDIC gain.
  assign tx    = COORD_W'(sum[0]) <<< 8;
  assign ty    = COORD_W'(sum[1]) <<< 8;
  assign zprod = 58'(sum[2]) * 58'sd27628053;

  always_ff @(posedge clk) begin
    if (en) begin
      if (sum[0] < 0) begin
        x0 <= -tx;
        y0 <= -ty;
        z0 <= (sum[1] >= 0) ? ANGLE_W'(ANGLE_HALF_TURN) : -ANGLE_W'(ANGLE_HALF_TURN);
      end else begin
        x0 <= tx;
        y0 <= ty;
        z0 <= '0;
      end
      zg       <= COORD_W'(zprod >>> 16);
      out_word <= w2;
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

endmodule

FILE: rtl/core/spvs_cordic.sv
`timescale 1ns / 1ps
module spvs_cordic #(
  parameter int SIDE_W = 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [spvs_pkg::COORD_W-1:0]  x_in,
  input  logic signed [spvs_pkg::COORD_W-1:0]  y_in,
  input  logic signed [spvs_pkg::ANGLE_W-1:0]  z_in,
  input  logic [SIDE_W-1:0]                    side_in,
  output logic                                 out_valid,
  output logic signed [spvs_pkg::COORD_W-1:0]  x_out,
  output logic signed [spvs_pkg::ANGLE_W-1:0]  z_out,
  output logic [SIDE_W-1:0]                    side_out
);
  import spvs_pkg::*;

  logic signed [COORD_W-1:0] xs [CORDIC_STEPS+1];
  logic signed [COORD_W-1:0] ys [CORDIC_STEPS+1];
  logic signed [ANGLE_W-1:0] zs [CORDIC_STEPS+1];
  logic [SIDE_W-1:0]         side [CORDIC_STEPS+1];
  logic                      vld [CORDIC_STEPS+1];

  assign xs[0]   = x_in;
  assign ys[0]   = y_in;
  assign zs[0]   = z_in;
  assign side[0] = side_in;
  assign vld[0]  = in_valid;

  // One vectoring micro-rotation per register stage.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (!ys[i][COORD_W-1]) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_step(i);
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_step(i);
        end
        side[i+1] <= side[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
  end

  assign out_valid = vld[CORDIC_STEPS];
  assign x_out     = xs[CORDIC_STEPS];
  assign z_out     = zs[CORDIC_STEPS];
  assign side_out  = side[CORDIC_STEPS];

endmodule

FILE: rtl/core/spvs_pano_ram.sv
`timescale 1ns / 1ps
module spvs_pano_ram #(
  parameter int DEPTH = 4,
  parameter int AW    = 2
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          en,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [31:0]   rdata_a,
  output logic [31:0]   rdata_b
);

  logic [31:0] mem [DEPTH];

  // One write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (en) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: rtl/core/spvs_sample.sv
`timescale 1ns / 1ps
module spvs_sample #(
  parameter int PANO_MAX_HEIGHT = 1024,
  parameter int PANO_MAX_WIDTH  = 2048
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [spvs_pkg::ANGLE_W-1:0]  alat,
  input  logic signed [spvs_pkg::ANGLE_W-1:0]  alon,
  input  spvs_pkg::in_word_t                   in_word,
  input  logic [10:0]                          h,
  input  logic [11:0]                          w,
  output logic                                 res_valid,
  output spvs_pkg::out_word_t                  res_word
);
  import spvs_pkg::*;

  localparam int MEM_DEPTH = PANO_MAX_HEIGHT * PANO_MAX_WIDTH;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  // Stage A: angles to scaled coordinates.
  logic signed [ANGLE_W-1:0] lat_sum;
  logic [20:0]               lat_s, lon_u;
  logic                      a_valid;
  in_word_t                  a_word;
  logic [31:0]               a_latm;
  logic [32:0]               a_lonm;

  assign lat_sum = alat + ANGLE_W'(ANGLE_HALF_TURN / 2);
  assign lon_u   = 21'(alon + ANGLE_W'(ANGLE_HALF_TURN));

  always_comb begin
    if (lat_sum < 0) begin
      lat_s = '0;
    end else if (lat_sum > ANGLE_W'(ANGLE_HALF_TURN)) begin
      lat_s = 21'(ANGLE_HALF_TURN);
    end else begin
      lat_s = lat_sum[20:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_latm <= 32'(lat_s) * 32'(h);
      a_lonm <= 33'(lon_u) * 33'(w);
      a_word <= in_word;
    end
  end

  // Stage B: wrap at the top end and split into index and fraction.
  logic [19:0] latq, lonq, latw, lonw;
  logic [19:0] h_top, w_top;
  logic        b_valid;
  in_word_t    b_word;
  logic [10:0] b_p1;
  logic [11:0] b_l1;
  logic [7:0]  b_fp, b_fl;

  assign latq  = a_latm[31:12];
  assign lonq  = a_lonm[32:13];
  assign h_top = {1'b0, h, 8'h00};
  assign w_top = {w, 8'h00};
  assign latw  = (latq >= h_top) ? latq - h_top : latq;
  assign lonw  = (lonq >= w_top) ? lonq - w_top : lonq;

  always_ff @(posedge clk) begin
    if (en) begin
      b_p1   <= latw[18:8];
      b_fp   <= latw[7:0];
      b_l1   <= lonw[19:8];
      b_fl   <= lonw[7:0];
      b_word <= a_word;
    end
  end

  // Stage C: neighbor indexes, store addresses and bilinear weights.
  logic [10:0]       p2;
  logic [11:0]       l2;
  logic [8:0]        wr [2];
  logic [8:0]        wc [2];
  logic              c_valid, c_write_ok;
  in_word_t          c_word;
  logic [MEM_AW-1:0] c_addr [4];
  logic [MEM_AW-1:0] c_waddr;
  logic [WGT_W-1:0]  c_wgt [4];

  assign p2    = (b_p1 + 11'd1 == h) ? '0 : b_p1 + 11'd1;
  assign l2    = (b_l1 + 12'd1 == w) ? '0 : b_l1 + 12'd1;
  assign wr[0] = 9'd256 - 9'(b_fp);
  assign wr[1] = 9'(b_fp);
  assign wc[0] = 9'd256 - 9'(b_fl);
  assign wc[1] = 9'(b_fl);

  always_ff @(posedge clk) begin
    if (en) begin
      c_addr[0] <= MEM_AW'(b_p1) * MEM_AW'(PANO_MAX_WIDTH) + MEM_AW'(b_l1);
      c_addr[1] <= MEM_AW'(b_p1) * MEM_AW'(PANO_MAX_WIDTH) + MEM_AW'(l2);
      c_addr[2] <= MEM_AW'(p2) * MEM_AW'(PANO_MAX_WIDTH) + MEM_AW'(b_l1);
      c_addr[3] <= MEM_AW'(p2) * MEM_AW'(PANO_MAX_WIDTH) + MEM_AW'(l2);
      c_waddr   <= MEM_AW'(b_word.pano_row) * MEM_AW'(PANO_MAX_WIDTH)
                   + MEM_AW'(b_word.pano_col);
      c_write_ok <= (b_word.command == CMD_WRITE)
                    && (32'(b_word.pano_row) < PANO_MAX_HEIGHT)
                    && (32'(b_word.pano_col) < PANO_MAX_WIDTH);
      for (int k = 0; k < 4; k++) begin
        c_wgt[k] <= WGT_W'(wr[k / 2] * wc[k % 2]);
      end
      c_word <= b_word;
    end
  end

  // Stage D: two copies of the store, each read at two addresses.
  logic [31:0] ent [4];
  logic        ram_we;
  logic        d_valid;
  in_word_t    d_word;
  logic [WGT_W-1:0] d_wgt [4];

  assign ram_we = en && c_valid && c_write_ok;

  spvs_pano_ram #(.DEPTH(MEM_DEPTH), .AW(MEM_AW)) u_ram_top (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (c_waddr),
    .wdata   ({c_word.mask_in, c_word.blue_in, c_word.green_in, c_word.red_in}),
    .en      (en),
    .raddr_a (c_addr[0]),
    .raddr_b (c_addr[1]),
    .rdata_a (ent[0]),
    .rdata_b (ent[1])
  );

  spvs_pano_ram #(.DEPTH(MEM_DEPTH), .AW(MEM_AW)) u_ram_bot (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (c_waddr),
    .wdata   ({c_word.mask_in, c_word.blue_in, c_word.green_in, c_word.red_in}),
    .en      (en),
    .raddr_a (c_addr[2]),
    .raddr_b (c_addr[3]),
    .rdata_a (ent[2]),
    .rdata_b (ent[3])
  );

  always_ff @(posedge clk) begin
    if (en) begin
      d_wgt  <= c_wgt;
      d_word <= c_word;
    end
  end

  // Stage E: weighted channel products.
  logic       e_valid;
  in_word_t   e_word;
  logic [7:0] e_mask;
  logic [24:0] e_prod [4][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        for (int ch = 0; ch < 3; ch++) begin
          e_prod[k][ch] <= 25'(ent[k][8*ch +: 8]) * 25'(d_wgt[k]);
        end
      end
      e_mask <= ent[0][31:24];
      e_word <= d_word;
    end
  end

  // Sum the four neighbors and round away the low 8 bits of the weight fraction.
  logic [26:0] acc [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      acc[ch] = 27'(e_prod[0][ch]) + 27'(e_prod[1][ch]) + 27'(e_prod[2][ch])
                + 27'(e_prod[3][ch]) + 27'd128;
    end
  end

  assign res_valid          = e_valid && (e_word.command == CMD_PROJECT);
  assign res_word.red_out   = acc[0][23:8];
  assign res_word.green_out = acc[1][23:8];
  assign res_word.blue_out  = acc[2][23:8];
  assign res_word.mask_out  = e_mask;
  assign res_word.echo_row  = e_word.view_row;
  assign res_word.echo_col  = e_word.view_col;

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
      e_valid <= d_valid;
    end
  end

endmodule

FILE: rtl/core/spherical_panorama_view_sampler.sv
`timescale 1ns / 1ps
// Spherical panorama view sampler.
// The input channel (in_valid/in_ready/in_data) takes one word per cycle. A write
// word stores RGB and mask at one panorama entry and gives no result. A project
// word rotates the ray of one view pixel, turns it into latitude and longitude with
// two 20-stage CORDIC pipelines, and returns one result word on out_valid/out_ready:
// bilinear RGB times 256, the mask of the nearest-lower entry and the pixel echoed.
// An accepted word passes 3 rotation stages, 40 CORDIC stages, 5 sampling stages
// with the store read, and the output register. Throughput is one word per cycle
// unless the output stalls; the store is kept in two copies, each read at two
// addresses, so all four neighbors are read in the same cycle. The user must write
// configuration through cfg_we/cfg_index/cfg_data only while no word is in flight;
// the block does not enforce it. Reset clears all valid bits and loads the identity
// rotation, focal length 512 and a 1024 x 2048 panorama; store contents are
// undefined until written. When the receiver holds out_ready low with a result
// waiting, the whole pipeline holds and in_ready drops; nothing is lost or repeated.
module spherical_panorama_view_sampler #(
  parameter int PANO_MAX_HEIGHT = 1024,
  parameter int PANO_MAX_WIDTH  = 2048,
  parameter int VIEW_HEIGHT     = 480,
  parameter int VIEW_WIDTH      = 640
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [spvs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [spvs_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  spvs_pkg::in_word_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output spvs_pkg::out_word_t                out_data
);
  import spvs_pkg::*;

  localparam int LON_SIDE_W = COORD_W + $bits(in_word_t);
  localparam int LAT_SIDE_W = ANGLE_W + $bits(in_word_t);

  // Configuration registers.
  logic [47:0] rot_row0, rot_row1, rot_row2;
  logic [11:0] focal_length;
  logic [10:0] pano_height;
  logic [11:0] pano_width;
  logic [10:0] h_eff;
  logic [11:0] w_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_row0     <= 48'd16384;
      rot_row1     <= 48'd1073741824;
      rot_row2     <= 48'd70368744177664;
      focal_length <= 12'd512;
      pano_height  <= 11'd1024;
      pano_width   <= 12'd2048;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROT_ROW0:     rot_row0     <= cfg_data;
        REG_ROT_ROW1:     rot_row1     <= cfg_data;
        REG_ROT_ROW2:     rot_row2     <= cfg_data;
        REG_FOCAL_LENGTH: focal_length <= cfg_data[11:0];
        REG_PANO_HEIGHT:  pano_height  <= cfg_data[10:0];
        REG_PANO_WIDTH:   pano_width   <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // Panorama size in use, at least 2 and limited to the store.
  always_ff @(posedge clk) begin
    if (pano_height < 11'd2) begin
      h_eff <= 11'd2;
    end else if (32'(pano_height) > PANO_MAX_HEIGHT) begin
      h_eff <= 11'(PANO_MAX_HEIGHT);
    end else begin
      h_eff <= pano_height;
    end
    if (pano_width < 12'd2) begin
      w_eff <= 12'd2;
    end else if (32'(pano_width) > PANO_MAX_WIDTH) begin
      w_eff <= 12'(PANO_MAX_WIDTH);
    end else begin
      w_eff <= pano_width;
    end
  end

  // The pipeline advances unless a result waits at the output.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Rotation.
  logic                      p_valid;
  in_word_t                  p_word;
  logic signed [COORD_W-1:0] p_x, p_y, p_zg;
  logic signed [ANGLE_W-1:0] p_z;

  spvs_project #(.VIEW_HEIGHT(VIEW_HEIGHT), .VIEW_WIDTH(VIEW_WIDTH)) u_project (
    .clk          (clk),
    .rst          (rst),
    .en           (adv),
    .in_valid     (in_valid),
    .in_word      (in_data),
    .rot_row0     (rot_row0),
    .rot_row1     (rot_row1),
    .rot_row2     (rot_row2),
    .focal_length (focal_length),
    .out_valid    (p_valid),
    .out_word     (p_word),
    .x0           (p_x),
    .y0           (p_y),
    .z0           (p_z),
    .zg           (p_zg)
  );

  // Longitude, carrying the gained z along.
  logic                      lon_valid;
  logic signed [COORD_W-1:0] lon_mag;
  logic signed [ANGLE_W-1:0] lon_angle;
  logic [LON_SIDE_W-1:0]     lon_side;
  logic signed [COORD_W-1:0] lon_zg;
  in_word_t                  lon_word;

  spvs_cordic #(.SIDE_W(LON_SIDE_W)) u_cordic_lon (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (p_valid),
    .x_in      (p_x),
    .y_in      (p_y),
    .z_in      (p_z),
    .side_in   ({p_zg, p_word}),
    .out_valid (lon_valid),
    .x_out     (lon_mag),
    .z_out     (lon_angle),
    .side_out  (lon_side)
  );

  assign {lon_zg, lon_word} = lon_side;

  // Latitude from the xy magnitude and the gained z.
  logic                      lat_valid;
  logic signed [ANGLE_W-1:0] lat_angle, lat_lon;
  logic [LAT_SIDE_W-1:0]     lat_side;
  in_word_t                  lat_word;

  spvs_cordic #(.SIDE_W(LAT_SIDE_W)) u_cordic_lat (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (lon_valid),
    .x_in      (lon_mag),
    .y_in      (lon_zg),
    .z_in      ('0),
    .side_in   ({lon_angle, lon_word}),
    .out_valid (lat_valid),
    .x_out     (),
    .z_out     (lat_angle),
    .side_out  (lat_side)
  );

  assign {lat_lon, lat_word} = lat_side;

  // Coordinates, store access and blending.
  logic      res_valid;
  out_word_t res_word;

  spvs_sample #(
    .PANO_MAX_HEIGHT (PANO_MAX_HEIGHT),
    .PANO_MAX_WIDTH  (PANO_MAX_WIDTH)
  ) u_sample (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (lat_valid),
    .alat      (lat_angle),
    .alon      (lat_lon),
    .in_word   (lat_word),
    .h         (h_eff),
    .w         (w_eff),
    .res_valid (res_valid),
    .res_word  (res_word)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= res_word;
    end
  end

endmodule

FILE: rtl/core/spvs_checker.sv
`timescale 1ns / 1ps
module spvs_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input spvs_pkg::out_word_t out_data
);

  // A waiting result word stays.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // A waiting result word keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // With the output empty the block takes input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // A stalled output stalls the input.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind spherical_panorama_view_sampler spvs_checker u_spvs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
